>>> rtl/ffha_pkg.sv
package ffha_pkg;

	localparam int HEAP_BYTES   = 2048;
	localparam int HEADER_BYTES = 16;
	localparam int ALIGN_BYTES  = 8;

	localparam int REQ_W    = 12;
	localparam int POS_W    = $clog2(HEAP_BYTES);
	localparam int GRAN_LSB = $clog2(ALIGN_BYTES);
	localparam int AW       = POS_W - GRAN_LSB;
	localparam int NUM_GRAN = HEAP_BYTES / ALIGN_BYTES;
	localparam int WANT_W   = REQ_W + 1;
	localparam int SIZE_W   = 16;
	localparam int ALU_W    = SIZE_W + 2;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_SUB = 1'b1;

	typedef struct packed {
		logic              free;
		logic [SIZE_W-1:0] size;
	} hdr_t;

	typedef struct packed {
		logic             rd;
		logic             wr;
		logic [AW-1:0]    raddr;
		logic [AW-1:0]    waddr;
		hdr_t             wdata;
	} mem_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             op;
	} alu_req_t;

endpackage

>>> rtl/ffha_alu.sv
module ffha_alu
	import ffha_pkg::*;
(
	input  alu_req_t         req,
	output logic [ALU_W-1:0] y,
	output logic             ge
);

	logic [ALU_W:0] sum;

	// single adder; subtract is a + ~b + 1, carry out means a >= b
	always_comb begin
		sum = {1'b0, req.a} + {1'b0, (req.op == OP_SUB) ? ~req.b : req.b}
			+ {{ALU_W{1'b0}}, (req.op == OP_SUB)};
		y   = sum[ALU_W-1:0];
		ge  = sum[ALU_W];
	end

endmodule

>>> rtl/ffha_hdr_mem.sv
module ffha_hdr_mem
	import ffha_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output hdr_t     rdata
);

	hdr_t          mem_q [NUM_GRAN];
	hdr_t          rd_s1;
	logic          rd_zero_s1;
	logic          zero_written_q;
	hdr_t          zero_init;

	assign zero_init = '{free: 1'b1, size: SIZE_W'(HEAP_BYTES - HEADER_BYTES)};

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.rd) begin
			rd_s1 <= mem_q[req.raddr];
		end
	end

	// granule 0 holds the initial whole-heap block until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_written_q <= 1'b0;
			rd_zero_s1     <= 1'b0;
		end else begin
			if (req.wr && req.waddr == '0) begin
				zero_written_q <= 1'b1;
			end
			if (req.rd) begin
				rd_zero_s1 <= (req.raddr == '0) && !zero_written_q;
			end
		end
	end

	assign rdata = rd_zero_s1 ? zero_init : rd_s1;

endmodule

>>> rtl/first_fit_heap_allocator_top.sv
// First-fit heap allocator over a 2048-byte heap with 16-byte in-band headers.
// mode 0 allocates request_bytes (rounded up to 8) and returns the payload
// offset, or granted 0 on a zero or unsatisfiable request. mode 1 frees the
// block at block_offset and merges it with the free blocks after it; offset 0
// is a no-op that still reports granted. One request is worked at a time and
// in_stall stays high until it is done. All arithmetic runs through one shared
// adder and headers come from a header memory with a registered read. No
// clearing pass follows reset.
module first_fit_heap_allocator_top
	import ffha_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	input  logic [REQ_W-1:0]  request_bytes,
	input  logic [POS_W-1:0]  block_offset,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              granted,
	output logic [POS_W-1:0]  payload_offset
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_A_HDR = 4'd1;
	localparam logic [3:0] S_A_NX1 = 4'd2;
	localparam logic [3:0] S_A_NX2 = 4'd3;
	localparam logic [3:0] S_A_SPL = 4'd4;
	localparam logic [3:0] S_A_SPA = 4'd5;
	localparam logic [3:0] S_A_SPB = 4'd6;
	localparam logic [3:0] S_A_WR  = 4'd7;
	localparam logic [3:0] S_A_FIN = 4'd8;
	localparam logic [3:0] S_F_HDR = 4'd9;
	localparam logic [3:0] S_F_NX1 = 4'd10;
	localparam logic [3:0] S_F_NX2 = 4'd11;
	localparam logic [3:0] S_F_CHK = 4'd12;
	localparam logic [3:0] S_F_ADD = 4'd13;

	localparam logic [ALU_W-1:0] HDR_A   = ALU_W'(HEADER_BYTES);
	localparam logic [ALU_W-1:0] HEAP_A  = ALU_W'(HEAP_BYTES);
	localparam logic [ALU_W-1:0] RND_A   = ALU_W'(ALIGN_BYTES - 1);
	localparam logic [ALU_W-1:0] ALIGN_A = ALU_W'(ALIGN_BYTES);

	logic [3:0]        state_q, state_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [WANT_W-1:0] want_q, want_d;
	logic [SIZE_W-1:0] hsize_q, hsize_d;
	logic [ALU_W-1:0]  acc_q, acc_d;
	logic              out_valid_q;
	logic              granted_q;
	logic [POS_W-1:0]  offset_q;

	alu_req_t          alu;
	logic [ALU_W-1:0]  alu_y;
	logic              alu_ge;
	mem_req_t          mreq;
	hdr_t              rhdr;

	logic              out_free;
	logic              accept;
	logic              res_set;
	logic              res_granted;
	logic [POS_W-1:0]  res_offset;

	ffha_alu u_alu (
		.req (alu),
		.y   (alu_y),
		.ge  (alu_ge)
	);

	ffha_hdr_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rdata  (rhdr)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d     = state_q;
		pos_d       = pos_q;
		want_d      = want_q;
		hsize_d     = hsize_q;
		acc_d       = acc_q;
		alu         = '{a: '0, b: '0, op: OP_ADD};
		mreq        = '0;
		res_set     = 1'b0;
		res_granted = 1'b0;
		res_offset  = '0;

		case (state_q)
			S_IDLE: begin
				if (mode == 1'b0) begin
					alu = '{a: ALU_W'(request_bytes), b: RND_A, op: OP_ADD};
				end else begin
					alu = '{a: ALU_W'(block_offset), b: HDR_A, op: OP_SUB};
				end
				if (accept) begin
					if (mode == 1'b0) begin
						if (request_bytes == '0) begin
							res_set = 1'b1;
						end else begin
							want_d = alu_y[WANT_W-1:0] & ~WANT_W'(ALIGN_BYTES - 1);
							pos_d  = '0;
							mreq.rd    = 1'b1;
							mreq.raddr = '0;
							state_d    = S_A_HDR;
						end
					end else if (block_offset == '0) begin
						res_set     = 1'b1;
						res_granted = 1'b1;
					end else if (!alu_ge) begin
						res_set = 1'b1;
					end else begin
						pos_d      = alu_y[POS_W-1:0];
						mreq.rd    = 1'b1;
						mreq.raddr = alu_y[POS_W-1:GRAN_LSB];
						state_d    = S_F_HDR;
					end
				end
			end

			S_A_HDR: begin
				alu     = '{a: ALU_W'(rhdr.size), b: ALU_W'(want_q), op: OP_SUB};
				hsize_d = rhdr.size;
				acc_d   = alu_y;
				state_d = (rhdr.free && alu_ge) ? S_A_SPL : S_A_NX1;
			end

			S_A_NX1: begin
				alu     = '{a: ALU_W'(pos_q), b: ALU_W'(hsize_q), op: OP_ADD};
				acc_d   = alu_y;
				state_d = S_A_NX2;
			end

			S_A_NX2: begin
				alu = '{a: acc_q, b: HDR_A, op: OP_ADD};
				if (alu_y >= HEAP_A) begin
					// end of chain, no fit
					if (out_free) begin
						res_set = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					pos_d      = alu_y[POS_W-1:0];
					mreq.rd    = 1'b1;
					mreq.raddr = alu_y[POS_W-1:GRAN_LSB];
					state_d    = S_A_HDR;
				end
			end

			S_A_SPL: begin
				// acc holds size - want; split when it covers a header plus one granule
				alu = '{a: acc_q, b: HDR_A, op: OP_SUB};
				if (alu_ge && alu_y >= ALIGN_A) begin
					hsize_d = alu_y[SIZE_W-1:0];
					state_d = S_A_SPA;
				end else begin
					mreq.wr    = 1'b1;
					mreq.waddr = pos_q[POS_W-1:GRAN_LSB];
					mreq.wdata = '{free: 1'b0, size: hsize_q};
					state_d    = S_A_FIN;
				end
			end

			S_A_SPA: begin
				alu     = '{a: ALU_W'(pos_q), b: ALU_W'(want_q), op: OP_ADD};
				acc_d   = alu_y;
				state_d = S_A_SPB;
			end

			S_A_SPB: begin
				alu = '{a: acc_q, b: HDR_A, op: OP_ADD};
				if (alu_y < HEAP_A) begin
					mreq.wr    = 1'b1;
					mreq.waddr = alu_y[POS_W-1:GRAN_LSB];
					mreq.wdata = '{free: 1'b1, size: hsize_q};
				end
				state_d = S_A_WR;
			end

			S_A_WR: begin
				mreq.wr    = 1'b1;
				mreq.waddr = pos_q[POS_W-1:GRAN_LSB];
				mreq.wdata = '{free: 1'b0, size: SIZE_W'(want_q)};
				state_d    = S_A_FIN;
			end

			S_A_FIN: begin
				alu = '{a: ALU_W'(pos_q), b: HDR_A, op: OP_ADD};
				if (out_free) begin
					res_set     = 1'b1;
					res_granted = 1'b1;
					res_offset  = alu_y[POS_W-1:0];
					state_d     = S_IDLE;
				end
			end

			S_F_HDR: begin
				hsize_d    = rhdr.size;
				mreq.wr    = 1'b1;
				mreq.waddr = pos_q[POS_W-1:GRAN_LSB];
				mreq.wdata = '{free: 1'b1, size: rhdr.size};
				state_d    = S_F_NX1;
			end

			S_F_NX1: begin
				alu     = '{a: ALU_W'(pos_q), b: ALU_W'(hsize_q), op: OP_ADD};
				acc_d   = alu_y;
				state_d = S_F_NX2;
			end

			S_F_NX2: begin
				alu = '{a: acc_q, b: HDR_A, op: OP_ADD};
				if (alu_y >= HEAP_A) begin
					if (out_free) begin
						res_set     = 1'b1;
						res_granted = 1'b1;
						state_d     = S_IDLE;
					end
				end else begin
					mreq.rd    = 1'b1;
					mreq.raddr = alu_y[POS_W-1:GRAN_LSB];
					state_d    = S_F_CHK;
				end
			end

			S_F_CHK: begin
				alu = '{a: ALU_W'(hsize_q), b: ALU_W'(rhdr.size), op: OP_ADD};
				if (!rhdr.free) begin
					// rdata stays put while waiting on the output register
					if (out_free) begin
						res_set     = 1'b1;
						res_granted = 1'b1;
						state_d     = S_IDLE;
					end
				end else begin
					acc_d   = alu_y;
					state_d = S_F_ADD;
				end
			end

			S_F_ADD: begin
				alu        = '{a: acc_q, b: HDR_A, op: OP_ADD};
				hsize_d    = alu_y[SIZE_W-1:0];
				mreq.wr    = 1'b1;
				mreq.waddr = pos_q[POS_W-1:GRAN_LSB];
				mreq.wdata = '{free: 1'b1, size: alu_y[SIZE_W-1:0]};
				state_d    = S_F_NX1;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_set) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q   <= pos_d;
		want_q  <= want_d;
		hsize_q <= hsize_d;
		acc_q   <= acc_d;
		if (res_set) begin
			granted_q <= res_granted;
			offset_q  <= res_offset;
		end
	end

	assign out_valid      = out_valid_q;
	assign granted        = granted_q;
	assign payload_offset = offset_q;

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall)
		else $error("input taken while sequencer busy");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE) || out_valid)
		else $error("accepted request produced neither work nor result");

	a_fail_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !granted |-> payload_offset == '0)
		else $error("failed result carries a nonzero offset");

	a_grant_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && granted |-> payload_offset == '0
			|| payload_offset >= POS_W'(HEADER_BYTES))
		else $error("granted offset inside first header");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.wr |-> state_q != S_IDLE)
		else $error("header write while idle");

endmodule

>>> verif/first_fit_heap_allocator_top_tb.sv
`timescale 1ns / 100ps

module first_fit_heap_allocator_top_tb;
	import ffha_pkg::*;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam int RANDOM_ITEMS  = 1400;
	localparam int PHASE_ITEMS   = 200;
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_LIMIT    = 5000;
	localparam int SETTLE_CYCLES = 600;
	localparam int MAX_REQ       = (1 << REQ_W) - 1;
	localparam int MAX_OFFSET    = (1 << POS_W) - 1;

	typedef struct packed {
		logic             granted;
		logic [POS_W-1:0] payload_offset;
	} grant_t;

	// Shadow copy of the heap headers; predicts the grant for every accepted request.
	class heap_shadow;
		int unsigned blk_size [HEAP_BYTES];
		bit          hdr_free [HEAP_BYTES];
		bit          hdr_written [HEAP_BYTES];
		int unsigned live_offsets [$];
		grant_t      expected_grants [$];
		int          errors;
		int          alloc_ok;
		int          alloc_fail;
		int          free_ok;
		int          free_reject;

		function void reset_heap();
			foreach (blk_size[i]) begin
				blk_size[i] = 0;
				hdr_free[i] = 1'b0;
				hdr_written[i] = 1'b0;
			end
			blk_size[0] = HEAP_BYTES - HEADER_BYTES;
			hdr_free[0] = 1'b1;
			hdr_written[0] = 1'b1;
			live_offsets.delete();
			expected_grants.delete();
		endfunction

		function int unsigned size_at(int unsigned pos);
			return (pos < HEAP_BYTES) ? blk_size[pos] : 0;
		endfunction

		function void put_header(int unsigned pos, int unsigned size, bit is_free);
			// headers past the heap end are dropped
			if (pos < HEAP_BYTES) begin
				blk_size[pos] = size;
				hdr_free[pos] = is_free;
				hdr_written[pos] = 1'b1;
			end
		endfunction

		function int unsigned allocate(int unsigned bytes);
			int unsigned want;
			int unsigned pos;
			if (bytes == 0)
				return 0;
			want = ((bytes + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
			pos = 0;
			while (pos < HEAP_BYTES) begin
				if (hdr_free[pos] && blk_size[pos] >= want) begin
					if (blk_size[pos] >= want + HEADER_BYTES + ALIGN_BYTES) begin
						put_header(pos + HEADER_BYTES + want,
							blk_size[pos] - want - HEADER_BYTES, 1'b1);
						put_header(pos, want, 1'b0);
					end else begin
						put_header(pos, blk_size[pos], 1'b0);
					end
					return pos + HEADER_BYTES;
				end
				pos = pos + HEADER_BYTES + blk_size[pos];
			end
			return 0;
		endfunction

		function bit free_block(int unsigned off);
			int unsigned pos;
			int unsigned nxt;
			if (off == 0)
				return 1'b1;
			if (off < HEADER_BYTES)
				return 1'b0;
			pos = off - HEADER_BYTES;
			if (pos >= HEAP_BYTES)
				return 1'b0;
			hdr_free[pos] = 1'b1;
			// merge forward only
			nxt = pos + HEADER_BYTES + blk_size[pos];
			while (nxt < HEAP_BYTES && hdr_free[nxt]) begin
				blk_size[pos] += HEADER_BYTES + blk_size[nxt];
				nxt = pos + HEADER_BYTES + blk_size[pos];
			end
			return 1'b1;
		endfunction

		// Offset of some header that was written at least once, live or not.
		function int unsigned stale_offset();
			int unsigned pos;
			repeat (8) begin
				pos = ALIGN_BYTES *
					$urandom_range(0, (MAX_OFFSET - HEADER_BYTES) / ALIGN_BYTES);
				if (hdr_written[pos])
					return pos + HEADER_BYTES;
			end
			return HEADER_BYTES;
		endfunction

		function void note_request(logic m, int unsigned req, int unsigned off);
			grant_t      g;
			int unsigned r;
			int          idx [$];
			if (m == MODE_ALLOC) begin
				r = allocate(req);
				g.granted = (r != 0);
				g.payload_offset = r[POS_W-1:0];
				if (g.granted) begin
					live_offsets.push_back(r);
					alloc_ok++;
				end else begin
					alloc_fail++;
				end
			end else begin
				g.granted = free_block(off);
				g.payload_offset = '0;
				idx = live_offsets.find_first_index(x) with (x == off);
				if (idx.size() != 0)
					live_offsets.delete(idx[0]);
				if (g.granted)
					free_ok++;
				else
					free_reject++;
			end
			expected_grants.push_back(g);
		endfunction

		function void check_grant(logic granted, logic [POS_W-1:0] offset);
			grant_t want_g;
			if (expected_grants.size() == 0) begin
				$error("unexpected result: granted %0b payload_offset %0d", granted, offset);
				errors++;
				return;
			end
			want_g = expected_grants.pop_front();
			if (granted !== want_g.granted) begin
				$error("granted: expected %0b, actual %0b", want_g.granted, granted);
				errors++;
			end
			if (offset !== want_g.payload_offset) begin
				$error("payload_offset: expected %0d, actual %0d",
					want_g.payload_offset, offset);
				errors++;
			end
		endfunction

		function int pending();
			return expected_grants.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              mode;
	logic [REQ_W-1:0]  request_bytes;
	logic [POS_W-1:0]  block_offset;
	logic              out_valid;
	logic              out_stall;
	logic              granted;
	logic [POS_W-1:0]  payload_offset;

	heap_shadow heap;
	bit         sender_idles;
	bit         receiver_idles;
	bit         hold_off_pending;
	int         items_sent;
	int         idle_cycles;

	first_fit_heap_allocator_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.request_bytes  (request_bytes),
		.block_offset   (block_offset),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.granted        (granted),
		.payload_offset (payload_offset)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned idle_len(bit enabled);
		int unsigned r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned alloc_size();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return 0;
		if (r < 6)
			return $urandom_range(HEAP_BYTES - HEADER_BYTES + 1, MAX_REQ);
		if (r < 10)
			return $urandom_range(401, HEAP_BYTES - HEADER_BYTES);
		if (r < 30)
			return $urandom_range(65, 400);
		return $urandom_range(1, 64);
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_request(logic m, int unsigned req, int unsigned off);
		int unsigned gap;
		gap = idle_len(sender_idles);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		request_bytes <= REQ_W'(req);
		block_offset <= POS_W'(off);
		do @(posedge clk); while (in_stall);
		heap.note_request(m, req, off);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic random_request();
		int unsigned pick;
		int unsigned i;
		pick = $urandom_range(0, 99);
		if (pick < 2 || heap.live_offsets.size() > 24) begin
			// free everything in random order
			while (heap.live_offsets.size() != 0) begin
				i = $urandom_range(0, heap.live_offsets.size() - 1);
				send_request(MODE_FREE, $urandom_range(0, MAX_REQ), heap.live_offsets[i]);
			end
		end else if (pick < 52 || (pick < 87 && heap.live_offsets.size() == 0)) begin
			send_request(MODE_ALLOC, alloc_size(), $urandom_range(0, MAX_OFFSET));
		end else if (pick < 87) begin
			i = $urandom_range(0, heap.live_offsets.size() - 1);
			send_request(MODE_FREE, $urandom_range(0, MAX_REQ), heap.live_offsets[i]);
		end else if (pick < 91) begin
			send_request(MODE_FREE, $urandom_range(0, MAX_REQ), 0);
		end else if (pick < 95) begin
			send_request(MODE_FREE, $urandom_range(0, MAX_REQ),
				$urandom_range(1, HEADER_BYTES - 1));
		end else begin
			send_request(MODE_FREE, $urandom_range(0, MAX_REQ), heap.stale_offset());
		end
	endtask

	// Receiver: random stalls, or one long counted hold-off on request.
	initial begin
		int unsigned n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				n = idle_len(receiver_idles);
				out_stall <= (n != 0);
				if (n > 1)
					repeat (n - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			heap.check_grant(granted, payload_offset);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, heap.pending());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int phase;
		int next_phase;
		int stop_at;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_ALLOC;
		request_bytes = '0;
		block_offset = '0;
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		hold_off_pending = 1'b0;
		items_sent = 0;
		idle_cycles = 0;
		heap = new;
		heap.reset_heap();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: failures, exact fit, split threshold, null and short frees, merges
		send_request(MODE_ALLOC, 0, MAX_OFFSET);
		send_request(MODE_ALLOC, MAX_REQ, 0);
		send_request(MODE_ALLOC, 2033, 0);
		send_request(MODE_ALLOC, 2032, 0);
		send_request(MODE_ALLOC, 1, 0);
		send_request(MODE_FREE, 0, 16);
		send_request(MODE_FREE, MAX_REQ, 0);
		send_request(MODE_FREE, 0, 15);
		send_request(MODE_FREE, 0, 1);
		send_request(MODE_ALLOC, 2016, 0);
		send_request(MODE_FREE, 0, 16);
		send_request(MODE_ALLOC, 2008, 0);
		send_request(MODE_ALLOC, 8, 0);
		send_request(MODE_FREE, 0, 2040);
		send_request(MODE_FREE, 0, 16);
		send_request(MODE_ALLOC, 1, 0);
		send_request(MODE_ALLOC, 9, 0);
		send_request(MODE_ALLOC, 100, 0);
		send_request(MODE_FREE, 0, 72);
		send_request(MODE_FREE, 0, 40);
		send_request(MODE_FREE, 0, 40);
		send_request(MODE_FREE, 0, 16);
		// stale header left behind by an earlier merge
		send_request(MODE_FREE, 0, 2040);
		send_request(MODE_ALLOC, 2048, 0);

		phase = 0;
		next_phase = items_sent;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			if (items_sent >= next_phase) begin
				case (phase % 4)
					0: begin
						sender_idles = 1'b1;
						receiver_idles = 1'b1;
					end
					1: begin
						sender_idles = 1'b0;
						receiver_idles = 1'b0;
					end
					2: begin
						sender_idles = 1'b1;
						receiver_idles = 1'b0;
						hold_off_pending = 1'b1;
					end
					default: begin
						sender_idles = 1'b0;
						receiver_idles = 1'b1;
					end
				endcase
				phase++;
				next_phase += PHASE_ITEMS;
			end
			random_request();
		end
		in_valid <= 1'b0;

		while (heap.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d allocations granted, %0d refused,",
			items_sent, heap.alloc_ok, heap.alloc_fail);
		$display("%0d frees done, %0d rejected, idle and busy phases, a %0d-cycle hold-off",
			heap.free_ok, heap.free_reject, HOLD_CYCLES);
		if (heap.pending() != 0) begin
			$error("%0d results never arrived", heap.pending());
			heap.errors++;
		end
		if (heap.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> sim.f
rtl/ffha_pkg.sv
rtl/ffha_alu.sv
rtl/ffha_hdr_mem.sv
rtl/first_fit_heap_allocator_top.sv
verif/first_fit_heap_allocator_top_tb.sv
